// ===== sv/dsd_enc_pkg.sv =====
`default_nettype none

package dsd_enc_pkg;

  typedef logic [15:0] seg_pat_t;

  localparam int unsigned NUM_POS   = 6;
  localparam int unsigned NUM_DIV   = NUM_POS - 1;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned DEC_W     = 20;  // 999999 fits in 20 bits
  localparam int unsigned RECIP_W   = 21;
  localparam int unsigned PROD_W    = DEC_W + RECIP_W;
  localparam logic [VAL_W-1:0] LIMIT = 32'd1000000;

  // x / d == (x * m) >> s for every x below 2**DEC_W,
  // with s = DEC_W + ceil(log2 d) and m = ceil(2**s / d)
  // index 0 divides by 100000, index 4 by 10
  localparam logic [RECIP_W-1:0] RECIP_MUL [NUM_DIV] = '{
    21'd1374390, 21'd1717987, 21'd1073742, 21'd1342178, 21'd1677722
  };
  localparam int unsigned RECIP_SHIFT [NUM_DIV] = '{37, 34, 30, 27, 24};

  localparam seg_pat_t BLANK_PAT = 16'h0000;

  localparam seg_pat_t ERROR_PAT [NUM_POS] = '{
    16'h0000, 16'h9F00, 16'hCF02, 16'hCF02, 16'hFC00, 16'hCF02
  };

  function automatic seg_pat_t digit_pat(input logic [3:0] d);
    seg_pat_t p;
    case (d)
      4'd0:    p = 16'hFC28;
      4'd1:    p = 16'h6020;
      4'd2:    p = 16'hDB00;
      4'd3:    p = 16'hF300;
      4'd4:    p = 16'h6700;
      4'd5:    p = 16'hB700;
      4'd6:    p = 16'hBF00;
      4'd7:    p = 16'hE400;
      4'd8:    p = 16'hFF00;
      default: p = 16'hF700;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== sv/decimal_segment_display_encoder.sv =====
// Decimal segment display encoder: one 32-bit unsigned value in, six 16-bit
// segment patterns plus an overflow flag out. A request is taken on every
// clock edge where start is high; busy is tied low, so the block takes one
// request per cycle with no gaps. Each result passes the input register, then
// one pass of constant-reciprocal multipliers and table lookups into the result
// register, and is held on the out_ ports for exactly one cycle, marked by
// out_valid. The receiver cannot stall: a result not captured in its strobe
// cycle is gone. Values of 1000000 or more show blank E R R O R and raise
// out_overflow.
`default_nettype none

module decimal_segment_display_encoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] in_value,
  output logic             out_valid,
  output logic [15:0]      out_pos1_pattern,
  output logic [15:0]      out_pos2_pattern,
  output logic [15:0]      out_pos3_pattern,
  output logic [15:0]      out_pos4_pattern,
  output logic [15:0]      out_pos5_pattern,
  output logic [15:0]      out_pos6_pattern,
  output logic             out_overflow
);

  localparam int unsigned DEC_W  = dsd_enc_pkg::DEC_W;
  localparam int unsigned NPOS   = dsd_enc_pkg::NUM_POS;
  localparam int unsigned NDIV   = dsd_enc_pkg::NUM_DIV;
  localparam int unsigned PROD_W = dsd_enc_pkg::PROD_W;
  localparam int unsigned RCP_W  = dsd_enc_pkg::RECIP_W;
  localparam int unsigned TEN_W  = DEC_W + 4;

  // input stage
  logic                            in_vld_r;
  logic [dsd_enc_pkg::VAL_W-1:0]   val_r;

  // result stage
  logic                            out_vld_r;
  logic                            ovf_r;
  logic                            ovf_nxt;
  dsd_enc_pkg::seg_pat_t           pat_r   [NPOS];
  dsd_enc_pkg::seg_pat_t           pat_nxt [NPOS];

  // quotients value / place, place from 100000 down to 1
  logic [DEC_W-1:0]  quo     [NPOS];
  logic [PROD_W-1:0] prod    [NDIV];
  logic [3:0]        digit   [NPOS];
  logic [TEN_W-1:0]  ten_quo [NPOS];
  logic [TEN_W-1:0]  diff    [NPOS];
  logic              seen    [NPOS];
  logic [DEC_W-1:0]  low_val;

  // never stalls, one request per cycle
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start & ~busy;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (start & ~busy) begin
      val_r <= in_value;
    end
  end

  // only the low 20 bits matter once the value is known to be in range
  assign low_val = val_r[DEC_W-1:0];

  // each quotient is an independent constant-reciprocal multiply
  always_comb begin
    for (int k = 0; k < NDIV; k++) begin
      prod[k] = {{RCP_W{1'b0}}, low_val} * {{DEC_W{1'b0}}, dsd_enc_pkg::RECIP_MUL[k]};
      quo[k]  = DEC_W'(prod[k] >> dsd_enc_pkg::RECIP_SHIFT[k]);
    end
    quo[NPOS-1] = low_val;
  end

  // digit k is quo[k] - 10 * quo[k-1], since quo[k-1] == quo[k] / 10
  always_comb begin
    ten_quo[0] = '0;
    for (int k = 1; k < NPOS; k++) begin
      ten_quo[k] = ({4'b0, quo[k-1]} << 3) + ({4'b0, quo[k-1]} << 1);
    end
    for (int k = 0; k < NPOS; k++) begin
      diff[k]  = {4'b0, quo[k]} - ten_quo[k];
      digit[k] = diff[k][3:0];
    end
  end

  // leading zero blanking, rightmost position always shown; overflow selects the error patterns
  always_comb begin
    ovf_nxt = (val_r >= dsd_enc_pkg::LIMIT);
    for (int k = 0; k < NPOS; k++) begin
      if (k == 0) begin
        seen[k] = (digit[k] != 4'd0);
      end else begin
        seen[k] = seen[k-1] | (digit[k] != 4'd0);
      end
      if (ovf_nxt) begin
        pat_nxt[k] = dsd_enc_pkg::ERROR_PAT[k];
      end else if (!seen[k] && (k < NPOS - 1)) begin
        pat_nxt[k] = dsd_enc_pkg::BLANK_PAT;
      end else begin
        pat_nxt[k] = dsd_enc_pkg::digit_pat(digit[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      ovf_r <= ovf_nxt;
      for (int k = 0; k < NPOS; k++) begin
        pat_r[k] <= pat_nxt[k];
      end
    end
  end

  assign out_valid        = out_vld_r;
  assign out_overflow     = ovf_r;
  assign out_pos1_pattern = pat_r[0];
  assign out_pos2_pattern = pat_r[1];
  assign out_pos3_pattern = pat_r[2];
  assign out_pos4_pattern = pat_r[3];
  assign out_pos5_pattern = pat_r[4];
  assign out_pos6_pattern = pat_r[5];

endmodule

`default_nettype wire
